>>> rtl/can_receive_id_dispatcher_unit_assert.svh
`ifndef CAN_RECEIVE_ID_DISPATCHER_UNIT_ASSERT_SVH
`define CAN_RECEIVE_ID_DISPATCHER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CRID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRID_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/can_rid_pkg.sv
package can_rid_pkg;

    localparam int ENC_SLOTS_DEF  = 4;
    localparam int LINE_SLOTS_DEF = 4;
    localparam int ID_W           = 11;
    localparam int TAB_W          = 44;
    localparam int CNT_W          = 3;
    localparam int DATA_W         = 64;
    localparam int TIME_W         = 32;
    localparam int BOX48_W        = 48;
    localparam int ENC_VAL_W      = 32;
    localparam int Q_DEPTH        = 2;
    localparam int PADDR_W        = 6;
    localparam int PDATA_W        = 64;
    localparam int LINE_KINDS     = 4;

    localparam logic [4:0] GROUP_FIXED   = 5'h03;
    localparam logic [4:0] GROUP_ENC     = 5'h04;
    // groups 0x08..0x0b share bits 4..2
    localparam logic [2:0] GROUP_LINE_HI = 3'b010;

    typedef enum logic [3:0] {
        KIND_NONE        = 4'd0,
        KIND_POSE        = 4'd1,
        KIND_VEL         = 4'd2,
        KIND_PAD         = 4'd3,
        KIND_ENC         = 4'd4,
        KIND_LINE        = 4'd5,
        KIND_LINE_HIGH   = 4'd6,
        KIND_LINE_LOW    = 4'd7,
        KIND_LINE_SCALED = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        REG_ENC_TAB  = 3'd0,
        REG_ENC_CNT  = 3'd1,
        REG_LINE_TAB = 3'd2,
        REG_LINE_CNT = 3'd3,
        REG_POSE_ID  = 3'd4,
        REG_VEL_ID   = 3'd5,
        REG_PAD_ID   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [DATA_W-1:0] frame_data;
        logic [TIME_W-1:0] arrival_us;
    } t_frame;

    typedef struct packed {
        logic [3:0]        match_kind;
        logic [1:0]        match_slot;
        logic [TIME_W-1:0] interval_us;
        logic [DATA_W-1:0] previous_data;
    } t_result;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        slot;
        logic [DATA_W-1:0] data;
        logic [TIME_W-1:0] arrival;
    } t_cmd;

    typedef struct packed {
        logic [TAB_W-1:0] enc_tab;
        logic [CNT_W-1:0] enc_cnt;
        logic [TAB_W-1:0] line_tab;
        logic [CNT_W-1:0] line_cnt;
        logic [ID_W-1:0]  pose_id;
        logic [ID_W-1:0]  vel_id;
        logic [ID_W-1:0]  pad_id;
    } t_cfg;

    function automatic t_kind line_kind(input logic [1:0] sub);
        t_kind k;
        unique case (sub)
            2'd0: k = KIND_LINE;
            2'd1: k = KIND_LINE_HIGH;
            2'd2: k = KIND_LINE_LOW;
            2'd3: k = KIND_LINE_SCALED;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/can_rid_front.sv
module can_rid_front
    import can_rid_pkg::*;
#(
    parameter int ENCODER_SLOTS = ENC_SLOTS_DEF,
    parameter int LINE_SLOTS    = LINE_SLOTS_DEF
) (
    input  t_frame i_frame,
    input  t_cfg   i_cfg,
    output t_cmd   o_cmd
);

    logic [4:0]      group;
    logic [1:0]      sub;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] or_val;

    assign id     = i_frame.frame_id;
    assign group  = id[10:6];
    assign sub    = group[1:0];
    assign or_val = {3'b000, sub, 6'b000000};

    always_comb begin
        o_cmd.kind    = KIND_NONE;
        o_cmd.slot    = 2'd0;
        o_cmd.data    = i_frame.frame_data;
        o_cmd.arrival = i_frame.arrival_us;
        if (group == GROUP_FIXED) begin
            priority if (id == i_cfg.pose_id) begin
                o_cmd.kind = KIND_POSE;
            end else if (id == i_cfg.vel_id) begin
                o_cmd.kind = KIND_VEL;
            end else if (id == i_cfg.pad_id) begin
                o_cmd.kind = KIND_PAD;
            end else begin
                o_cmd.kind = KIND_NONE;
            end
        end else if (group == GROUP_ENC) begin
            // descending scan: lowest matching slot wins
            for (int i = ENCODER_SLOTS - 1; i >= 0; i--) begin
                if (CNT_W'(i) < i_cfg.enc_cnt &&
                    i_cfg.enc_tab[i*ID_W +: ID_W] == id) begin
                    o_cmd.kind = KIND_ENC;
                    o_cmd.slot = 2'(i);
                end
            end
        end else if (group[4:2] == GROUP_LINE_HI) begin
            for (int i = LINE_SLOTS - 1; i >= 0; i--) begin
                if (CNT_W'(i) < i_cfg.line_cnt &&
                    (i_cfg.line_tab[i*ID_W +: ID_W] | or_val) == id) begin
                    o_cmd.kind = line_kind(sub);
                    o_cmd.slot = 2'(i);
                end
            end
        end
    end

endmodule

>>> rtl/can_rid_queue.sv
module can_rid_queue
    import can_rid_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/can_rid_back.sv
`include "can_receive_id_dispatcher_unit_assert.svh"

module can_rid_back
    import can_rid_pkg::*;
#(
    parameter int ENCODER_SLOTS = ENC_SLOTS_DEF,
    parameter int LINE_SLOTS    = LINE_SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [BOX48_W-1:0]   r_pose_box;
    logic [DATA_W-1:0]    r_vel_box;
    logic [BOX48_W-1:0]   r_pad_box;
    logic [TIME_W-1:0]    r_pose_time;
    logic [ENC_VAL_W-1:0] r_enc_val  [ENCODER_SLOTS];
    logic [TIME_W-1:0]    r_enc_time [ENCODER_SLOTS];
    logic [DATA_W-1:0]    r_line_box [LINE_KINDS][LINE_SLOTS];
    logic                 r_out_valid;
    t_result              r_out;

    logic    pop;
    logic [1:0] sub;
    t_result res;

    assign pop      = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop  = pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign sub      = 2'(4'(i_q_cmd.kind) - 4'(KIND_LINE));

    always_comb begin
        res               = '0;
        res.match_kind    = i_q_cmd.kind;
        res.match_slot    = i_q_cmd.slot;
        unique case (i_q_cmd.kind)
            KIND_POSE: begin
                res.previous_data = {16'h0000, r_pose_box};
                res.interval_us   = i_q_cmd.arrival - r_pose_time;
            end
            KIND_VEL: begin
                res.previous_data = r_vel_box;
            end
            KIND_PAD: begin
                res.previous_data = {16'h0000, r_pad_box};
            end
            KIND_ENC: begin
                for (int i = 0; i < ENCODER_SLOTS; i++) begin
                    if (i_q_cmd.slot == 2'(i)) begin
                        res.previous_data = {32'h0, r_enc_val[i]};
                        res.interval_us   = i_q_cmd.arrival - r_enc_time[i];
                    end
                end
            end
            KIND_LINE, KIND_LINE_HIGH, KIND_LINE_LOW, KIND_LINE_SCALED: begin
                for (int k = 0; k < LINE_KINDS; k++) begin
                    for (int i = 0; i < LINE_SLOTS; i++) begin
                        if (sub == 2'(k) && i_q_cmd.slot == 2'(i)) begin
                            res.previous_data = r_line_box[k][i];
                        end
                    end
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_box  <= '0;
            r_vel_box   <= '0;
            r_pad_box   <= '0;
            r_pose_time <= '0;
            for (int i = 0; i < ENCODER_SLOTS; i++) begin
                r_enc_val[i]  <= '0;
                r_enc_time[i] <= '0;
            end
            for (int k = 0; k < LINE_KINDS; k++) begin
                for (int i = 0; i < LINE_SLOTS; i++) begin
                    r_line_box[k][i] <= '0;
                end
            end
        end else if (pop) begin
            unique case (i_q_cmd.kind)
                KIND_POSE: begin
                    r_pose_box  <= i_q_cmd.data[BOX48_W-1:0];
                    r_pose_time <= i_q_cmd.arrival;
                end
                KIND_VEL: begin
                    r_vel_box <= i_q_cmd.data;
                end
                KIND_PAD: begin
                    r_pad_box <= i_q_cmd.data[BOX48_W-1:0];
                end
                KIND_ENC: begin
                    for (int i = 0; i < ENCODER_SLOTS; i++) begin
                        if (i_q_cmd.slot == 2'(i)) begin
                            r_enc_val[i]  <= i_q_cmd.data[ENC_VAL_W-1:0];
                            r_enc_time[i] <= i_q_cmd.arrival;
                        end
                    end
                end
                KIND_LINE, KIND_LINE_HIGH, KIND_LINE_LOW, KIND_LINE_SCALED: begin
                    for (int k = 0; k < LINE_KINDS; k++) begin
                        for (int i = 0; i < LINE_SLOTS; i++) begin
                            if (sub == 2'(k) && i_q_cmd.slot == 2'(i)) begin
                                r_line_box[k][i] <= i_q_cmd.data;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= res;
        end
    end

    `CRID_ASSERT_IMP(a_none_is_zero, r_out_valid && r_out.match_kind == KIND_NONE, r_out.match_slot == 2'd0 && r_out.interval_us == '0 && r_out.previous_data == '0, "unmatched word carries nonzero fields")
    `CRID_ASSERT_IMP(a_interval_kinds, r_out_valid && r_out.match_kind != KIND_POSE && r_out.match_kind != KIND_ENC, r_out.interval_us == '0, "interval on a kind without timestamp")
    `CRID_ASSERT_NXT(a_pose_time, pop && i_q_cmd.kind == KIND_POSE, r_pose_time == $past(i_q_cmd.arrival), "pose arrival time not recorded")

endmodule

>>> rtl/can_receive_id_dispatcher_unit.sv
// A word accepted on i_frame passes the combinational front compare into the two-entry
// queue and is then registered into o_result by the back with its mailbox update.
// Throughput: one word per cycle while the queue has room and i_result_ready does not stall.
// Reset (i_rst_n low, synchronous): clears the configuration registers, mailboxes and
// timestamps to zero, empties the queue and drops o_result_valid.
module can_receive_id_dispatcher_unit
    import can_rid_pkg::*;
#(
    parameter int ENCODER_SLOTS = ENC_SLOTS_DEF,
    parameter int LINE_SLOTS    = LINE_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_frame_valid,
    output logic               o_frame_ready,
    input  t_frame             i_frame,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output t_result            o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    t_cmd     front_cmd;
    t_cmd     q_cmd;
    logic     q_full, q_valid, q_pop;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ENC_TAB:  r_cfg.enc_tab  <= pwdata[TAB_W-1:0];
                REG_ENC_CNT:  r_cfg.enc_cnt  <= pwdata[CNT_W-1:0];
                REG_LINE_TAB: r_cfg.line_tab <= pwdata[TAB_W-1:0];
                REG_LINE_CNT: r_cfg.line_cnt <= pwdata[CNT_W-1:0];
                REG_POSE_ID:  r_cfg.pose_id  <= pwdata[ID_W-1:0];
                REG_VEL_ID:   r_cfg.vel_id   <= pwdata[ID_W-1:0];
                REG_PAD_ID:   r_cfg.pad_id   <= pwdata[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENC_TAB:  prdata = PDATA_W'(r_cfg.enc_tab);
            REG_ENC_CNT:  prdata = PDATA_W'(r_cfg.enc_cnt);
            REG_LINE_TAB: prdata = PDATA_W'(r_cfg.line_tab);
            REG_LINE_CNT: prdata = PDATA_W'(r_cfg.line_cnt);
            REG_POSE_ID:  prdata = PDATA_W'(r_cfg.pose_id);
            REG_VEL_ID:   prdata = PDATA_W'(r_cfg.vel_id);
            REG_PAD_ID:   prdata = PDATA_W'(r_cfg.pad_id);
            default:      prdata = '0;
        endcase
    end

    assign o_frame_ready = !q_full;

    can_rid_front #(
        .ENCODER_SLOTS (ENCODER_SLOTS),
        .LINE_SLOTS    (LINE_SLOTS)
    ) u_front (
        .i_frame (i_frame),
        .i_cfg   (r_cfg),
        .o_cmd   (front_cmd)
    );

    can_rid_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_frame_valid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    can_rid_back #(
        .ENCODER_SLOTS (ENCODER_SLOTS),
        .LINE_SLOTS    (LINE_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_result_valid),
        .i_ready   (i_result_ready),
        .o_result  (o_result)
    );

endmodule
